@@ hw/rtl/sqlkt_pkg.sv @@
package sqlkt_pkg;

    localparam int MAX_QUERY_BYTES = 65536;
    localparam int KW_CHARS        = 16;
    localparam int KW_IDX_W        = $clog2(KW_CHARS);
    localparam int KW_LEN_W        = $clog2(KW_CHARS + 1);
    localparam int KW_NUM          = 27;

    localparam logic [15:0] POS_LIMIT =
        ((MAX_QUERY_BYTES - 1) > 65535) ? 16'hFFFF : 16'(MAX_QUERY_BYTES - 1);
    localparam logic [15:0] LEN_LIMIT = 16'hFFFF;

    // result queue: one word enters per cycle while the input is not stalled, at most GRP_MAX results per word
    localparam int GRP_MAX    = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [4:0] t_kind;

    localparam t_kind KIND_NAME  = 5'd0;
    localparam t_kind KIND_OPEN  = 5'd23;
    localparam t_kind KIND_CLOSE = 5'd24;
    localparam t_kind KIND_COMMA = 5'd25;
    localparam t_kind KIND_END   = 5'd30;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;

    typedef enum logic [2:0] {
        MODE_START = 3'b001,
        MODE_WORD  = 3'b010,
        MODE_QUOTE = 3'b100
    } t_mode;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start_res;
        logic [15:0] length;
        logic        status;
        logic        final_res;
    } t_out;

    // results caused by one word, packed from index 0
    typedef struct packed {
        logic [1:0]         cnt;
        t_out [GRP_MAX-1:0] res;
    } t_grp;

    typedef logic [KW_CHARS-1:0][7:0] t_kwbuf;

    // keyword strings, right-justified in the vector (first char highest)
    localparam logic [KW_CHARS*8-1:0] KW_TEXT [KW_NUM] = '{
        "FROM", "CREATE", "SELECT", "SUM", "COUNT", "AVG", "MIN", "MAX",
        "DISTINCT", "LENGTH", {"EXTRACT", "_MINUTE"}, {"TRUNC", "_MINUTE"}, "LIMIT",
        {"CONST", "_INT"}, "IF", "COND", "THEN", "ELSE", "OFFSET", "+", "-",
        "ORDER", "WHERE", "HAVING", "GROUP", "AS", "AND"
    };

    localparam logic [KW_LEN_W-1:0] KW_LEN [KW_NUM] = '{
        5'd4, 5'd6, 5'd6, 5'd3, 5'd5, 5'd3, 5'd3, 5'd3,
        5'd8, 5'd6, 5'd14, 5'd12, 5'd5,
        5'd9, 5'd2, 5'd4, 5'd4, 5'd4, 5'd6, 5'd1, 5'd1,
        5'd5, 5'd5, 5'd6, 5'd5, 5'd2, 5'd3
    };

    localparam t_kind KW_KIND [KW_NUM] = '{
        5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8,
        5'd9, 5'd10, 5'd11, 5'd12, 5'd13,
        5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
        5'd22, 5'd26, 5'd26, 5'd27, 5'd28, 5'd29
    };

    // byte i of keyword k, counted from its first character
    function automatic logic [7:0] kw_byte(input int k, input int i);
        int sh;
        sh = (i < int'(KW_LEN[k])) ? (int'(KW_LEN[k]) - 1 - i) : 0;
        return KW_TEXT[k][sh*8 +: 8];
    endfunction

endpackage

@@ hw/rtl/sql_keyword_tokenizer.sv @@
// SQL keyword tokenizer. Takes one query byte per word (with a flag on the
// final byte) and returns tokens: kind, content offset, content length, an
// error status and a flag on the query's closing end marker. Each byte goes
// through an input register, is classified combinationally against the word
// buffer and all keywords in parallel, and its zero to three results enter
// an 8-entry result queue. A new byte is taken in every cycle in which the
// queue has room for three results beyond those owed to the byte already in
// the input register; results leave the queue one per cycle unless the
// output stalls, so the input stalls only when bytes cause results faster
// than the output takes them.
module sql_keyword_tokenizer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  sqlkt_pkg::t_in  i_in_data,
    output logic            o_in_stall,
    output logic            o_out_valid,
    output sqlkt_pkg::t_out o_out_data,
    input  logic            i_out_stall
);
    import sqlkt_pkg::*;

    logic                  acc, pend, pop;
    t_grp                  grp;
    logic [FIFO_CNT_W-1:0] count;
    logic [FIFO_CNT_W:0]   booked;

    // queue entries used or promised to the byte now in the input register
    assign booked     = (FIFO_CNT_W + 1)'(count) +
                        (pend ? (FIFO_CNT_W + 1)'(GRP_MAX) : '0);
    assign o_in_stall = (booked > (FIFO_CNT_W + 1)'(FIFO_DEPTH - GRP_MAX));
    assign acc        = i_in_valid && !o_in_stall;

    assign o_out_valid = (count != '0);
    assign pop         = o_out_valid && !i_out_stall;

    sqlkt_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_word  (i_in_data),
        .o_pend  (pend),
        .o_grp   (grp)
    );

    sqlkt_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grp   (grp),
        .i_pop   (pop),
        .o_head  (o_out_data),
        .o_count (count)
    );

endmodule

@@ hw/rtl/sqlkt_kw_match.sv @@
module sqlkt_kw_match (
    input  sqlkt_pkg::t_kwbuf i_buf,
    input  logic [15:0]       i_len,
    output sqlkt_pkg::t_kind  o_kind
);
    import sqlkt_pkg::*;

    // all table entries compared in parallel; at most one can hit
    always_comb begin
        logic hit;
        o_kind = KIND_NAME;
        for (int k = 0; k < KW_NUM; k++) begin
            hit = (i_len == 16'(KW_LEN[k]));
            for (int i = 0; i < KW_CHARS; i++) begin
                if (i < int'(KW_LEN[k]) && i_buf[i] != kw_byte(k, i)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                o_kind = KW_KIND[k];
            end
        end
    end

endmodule

@@ hw/rtl/sqlkt_lexer.sv @@
module sqlkt_lexer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_acc,
    input  sqlkt_pkg::t_in  i_word,
    output logic            o_pend,
    output sqlkt_pkg::t_grp o_grp
);
    import sqlkt_pkg::*;

    logic        r_v;
    t_in         r_in;
    t_mode       r_mode, n_mode;
    logic [15:0] r_pos, n_pos;
    logic [15:0] r_tstart, n_tstart;
    logic [15:0] r_tlen, n_tlen;
    t_kwbuf      r_buf, n_buf;
    logic        r_begun, n_begun;

    logic        ws, quote;
    t_kind       pk;
    logic [15:0] pos_inc;

    logic        a_v, a_word, b_v, c_v, c_status;
    logic [15:0] a_start, a_len, c_start, c_len;
    t_kind       kw_kind;
    t_out        slot [GRP_MAX];
    logic        slot_v [GRP_MAX];

    always_comb begin
        ws = (r_in.ch == CH_SPACE) || (r_in.ch >= CH_TAB && r_in.ch <= CH_CR);
        quote = (r_in.ch == CH_QUOTE);
        case (r_in.ch)
            CH_OPEN:  pk = KIND_OPEN;
            CH_CLOSE: pk = KIND_CLOSE;
            CH_COMMA: pk = KIND_COMMA;
            default:  pk = KIND_NAME;
        endcase
        pos_inc = (r_pos < POS_LIMIT) ? r_pos + 16'd1 : r_pos;
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = r_pos;
        n_tstart = r_tstart;
        n_tlen   = r_tlen;
        n_buf    = r_buf;
        n_begun  = r_begun;
        a_v      = 1'b0;
        a_word   = 1'b0;
        a_start  = r_tstart;
        a_len    = r_tlen;
        b_v      = 1'b0;
        c_v      = 1'b0;
        c_status = 1'b0;
        c_start  = '0;
        c_len    = '0;
        if (r_v) begin
            n_begun = 1'b1;
            case (r_mode)
                MODE_WORD: begin
                    if (ws || pk != KIND_NAME) begin
                        a_v    = 1'b1;
                        a_word = 1'b1;
                        n_mode = MODE_START;
                        b_v    = (pk != KIND_NAME);
                    end else begin
                        if (r_tlen < 16'(KW_CHARS)) begin
                            n_buf[r_tlen[KW_IDX_W-1:0]] = r_in.ch;
                        end
                        if (r_tlen < LEN_LIMIT) begin
                            n_tlen = r_tlen + 16'd1;
                        end
                    end
                end
                MODE_QUOTE: begin
                    if (quote) begin
                        a_v    = 1'b1;
                        n_mode = MODE_START;
                    end else if (r_tlen < LEN_LIMIT) begin
                        n_tlen = r_tlen + 16'd1;
                    end
                end
                default: begin
                    if (quote) begin
                        n_mode   = MODE_QUOTE;
                        n_tstart = pos_inc;
                        n_tlen   = '0;
                    end else if (pk != KIND_NAME) begin
                        b_v    = 1'b1;
                        n_mode = MODE_START;
                    end else if (ws) begin
                        // leading whitespace gives one empty name
                        if (!r_begun) begin
                            a_v     = 1'b1;
                            a_start = r_pos;
                            a_len   = '0;
                        end
                        n_mode = MODE_START;
                    end else begin
                        n_mode   = MODE_WORD;
                        n_tstart = r_pos;
                        n_tlen   = 16'd1;
                        n_buf[0] = r_in.ch;
                    end
                end
            endcase
            n_pos = pos_inc;

            if (r_in.last) begin
                c_v = 1'b1;
                if (n_mode == MODE_QUOTE) begin
                    c_start  = n_tstart;
                    c_len    = n_tlen;
                    c_status = 1'b1;
                end else begin
                    if (n_mode == MODE_WORD) begin
                        a_v     = 1'b1;
                        a_word  = 1'b1;
                        a_start = n_tstart;
                        a_len   = n_tlen;
                    end
                    c_start = n_pos;
                end
                n_mode   = MODE_START;
                n_pos    = '0;
                n_tstart = '0;
                n_tlen   = '0;
                n_begun  = 1'b0;
            end
        end
    end

    // buffer already holds the current byte when a word closes at the end
    sqlkt_kw_match u_match (
        .i_buf  (n_buf),
        .i_len  (a_len),
        .o_kind (kw_kind)
    );

    always_comb begin
        slot[0]   = '{kind: a_word ? kw_kind : KIND_NAME, start_res: a_start,
                      length: a_len, status: 1'b0, final_res: 1'b0};
        slot[1]   = '{kind: pk, start_res: r_pos, length: 16'd1,
                      status: 1'b0, final_res: 1'b0};
        slot[2]   = '{kind: KIND_END, start_res: c_start, length: c_len,
                      status: c_status, final_res: 1'b1};
        slot_v[0] = a_v;
        slot_v[1] = b_v;
        slot_v[2] = c_v;
        o_grp = '0;
        for (int i = 0; i < GRP_MAX; i++) begin
            if (slot_v[i]) begin
                o_grp.res[o_grp.cnt] = slot[i];
                o_grp.cnt = o_grp.cnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v      <= 1'b0;
            r_mode   <= MODE_START;
            r_pos    <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_begun  <= 1'b0;
        end else begin
            r_v      <= i_acc;
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_begun  <= n_begun;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_in <= i_word;
        end
        r_buf <= n_buf;
    end

    assign o_pend = r_v;

endmodule

@@ hw/rtl/sqlkt_res_fifo.sv @@
module sqlkt_res_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sqlkt_pkg::t_grp                    i_grp,
    input  logic                               i_pop,
    output sqlkt_pkg::t_out                    o_head,
    output logic [sqlkt_pkg::FIFO_CNT_W-1:0]   o_count
);
    import sqlkt_pkg::*;

    t_out                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < GRP_MAX; j++) begin
            if (j < int'(i_grp.cnt)) begin
                r_mem[r_wr + FIFO_PTR_W'(j)] <= i_grp.res[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + FIFO_PTR_W'(i_grp.cnt);
            r_rd  <= r_rd + FIFO_PTR_W'(i_pop);
            r_cnt <= r_cnt + FIFO_CNT_W'(i_grp.cnt) - FIFO_CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

@@ hw/rtl/sqlkt_checker.sv @@
module sqlkt_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_out_valid,
    input sqlkt_pkg::t_out o_out_data,
    input logic            i_out_stall
);
    import sqlkt_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output word changed");

    a_end_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.kind == KIND_END) == o_out_data.final_res))
        else $error("end marker and final flag disagree");

    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.kind == KIND_END)
        else $error("error status on a token that is not the end marker");

    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_OPEN || o_out_data.kind == KIND_CLOSE ||
                        o_out_data.kind == KIND_COMMA)
        |-> o_out_data.length == 16'd1)
        else $error("punctuation token with length other than one");

endmodule

bind sql_keyword_tokenizer sqlkt_checker u_chk (.*);

@@ tb/tb_sql_keyword_tokenizer.sv @@
module tb_sql_keyword_tokenizer;
    timeunit 1ns;
    timeprecision 1ps;

    import sqlkt_pkg::*;

    localparam int WORD_CHARS     = KW_CHARS;
    localparam int KWB            = WORD_CHARS * 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int PHASE_BYTES    = 12;
    localparam int KW_WORDS       = 27;

    localparam logic [15:0] POS_SAT = ((MAX_QUERY_BYTES - 1) > 65535) ?
        16'hFFFF : 16'(MAX_QUERY_BYTES - 1);
    localparam logic [15:0] LEN_SAT = 16'hFFFF;

    localparam logic [7:0] ASC_TAB   = 8'h09;
    localparam logic [7:0] ASC_CR    = 8'h0D;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_QUOTE = 8'h27;
    localparam logic [7:0] ASC_OPEN  = 8'h28;
    localparam logic [7:0] ASC_CLOSE = 8'h29;
    localparam logic [7:0] ASC_COMMA = 8'h2C;

    typedef enum logic [4:0] {
        TK_NAME = 5'd0, TK_FROM, TK_CREATE, TK_SELECT, TK_SUM, TK_COUNT, TK_AVG,
        TK_MIN, TK_MAX, TK_DISTINCT, TK_LENGTH, TK_XMINUTE, TK_TMINUTE,
        TK_LIMIT, TK_CINT, TK_IF, TK_COND, TK_THEN, TK_ELSE, TK_OFFSET,
        TK_PLUS, TK_MINUS, TK_ORDER, TK_OPEN, TK_CLOSE, TK_COMMA, TK_FILTER,
        TK_GROUP, TK_AS, TK_AND, TK_END
    } t_tok;

    typedef enum int {
        PH_STEADY, PH_TX_GAPS, PH_RX_STALLS, PH_BOTH, PH_HOLD
    } t_phase;

    string kw_words [KW_WORDS] = '{
        "FROM", "CREATE", "SELECT", "SUM", "COUNT", "AVG", "MIN", "MAX",
        "DISTINCT", "LENGTH", string'({"EXTRACT", "_MINUTE"}),
        string'({"TRUNC", "_MINUTE"}), "LIMIT",
        string'({"CONST", "_INT"}), "IF", "COND", "THEN", "ELSE", "OFFSET", "+", "-",
        "ORDER", "WHERE", "HAVING", "GROUP", "AS", "AND"
    };

    logic i_clk     = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    t_phase phase = PH_STEADY;
    t_in    byte_q [$];
    logic [7:0] pending_text [$];
    t_out   expected_tokens [$];
    t_out   next_token;
    int     queued_bytes = 0;
    int     errors       = 0;
    int     quiet_cycles = 0;
    int     hold_count   = 0;

    // tokenizer state as predicted
    t_mode       lex_mode   = MODE_START;
    logic [15:0] lex_pos    = '0;
    logic [15:0] tok_start  = '0;
    logic [15:0] tok_len    = '0;
    logic        query_open = 1'b0;
    logic [7:0]  word_buf [WORD_CHARS];

    sql_keyword_tokenizer dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (out_stall)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic is_space(input logic [7:0] c);
        return c == ASC_SPACE || (c >= ASC_TAB && c <= ASC_CR);
    endfunction

    function automatic t_tok punct_tok(input logic [7:0] c);
        case (c)
            ASC_OPEN:  return TK_OPEN;
            ASC_CLOSE: return TK_CLOSE;
            ASC_COMMA: return TK_COMMA;
            default:   return TK_NAME;
        endcase
    endfunction

    function automatic t_tok word_tok();
        logic [KWB-1:0] w;
        int             nz;
        if (tok_len > WORD_CHARS) return TK_NAME;
        w  = '0;
        nz = 0;
        for (int i = 0; i < int'(tok_len); i++) w = (w << 8) | KWB'(word_buf[i]);
        // zero bytes pack like leading padding, so the length must match too
        for (int i = 0; i < WORD_CHARS; i++) if (w[i*8 +: 8] != 8'h00) nz++;
        if (nz != int'(tok_len)) return TK_NAME;
        case (w)
            KWB'("FROM"):                 return TK_FROM;
            KWB'("CREATE"):               return TK_CREATE;
            KWB'("SELECT"):               return TK_SELECT;
            KWB'("SUM"):                  return TK_SUM;
            KWB'("COUNT"):                return TK_COUNT;
            KWB'("AVG"):                  return TK_AVG;
            KWB'("MIN"):                  return TK_MIN;
            KWB'("MAX"):                  return TK_MAX;
            KWB'("DISTINCT"):             return TK_DISTINCT;
            KWB'("LENGTH"):               return TK_LENGTH;
            KWB'({"EXTRACT", "_MINUTE"}): return TK_XMINUTE;
            KWB'({"TRUNC", "_MINUTE"}):   return TK_TMINUTE;
            KWB'("LIMIT"):                return TK_LIMIT;
            KWB'({"CONST", "_INT"}):      return TK_CINT;
            KWB'("IF"):                   return TK_IF;
            KWB'("COND"):                 return TK_COND;
            KWB'("THEN"):                 return TK_THEN;
            KWB'("ELSE"):                 return TK_ELSE;
            KWB'("OFFSET"):               return TK_OFFSET;
            KWB'("+"):                    return TK_PLUS;
            KWB'("-"):                    return TK_MINUS;
            KWB'("ORDER"):                return TK_ORDER;
            KWB'("WHERE"):                return TK_FILTER;
            KWB'("HAVING"):               return TK_FILTER;
            KWB'("GROUP"):                return TK_GROUP;
            KWB'("AS"):                   return TK_AS;
            KWB'("AND"):                  return TK_AND;
            default:                      return TK_NAME;
        endcase
    endfunction

    function automatic void add_token(input t_tok k, input logic [15:0] st,
                                      input logic [15:0] len, input logic stat,
                                      input logic fin);
        t_out r;
        r.kind      = k;
        r.start_res = st;
        r.length    = len;
        r.status    = stat;
        r.final_res = fin;
        expected_tokens.insert(expected_tokens.size(), r);
    endfunction

    task automatic lex_byte(input t_in b);
        logic [15:0] pos;
        logic        first;
        t_tok        pk;
        pos        = lex_pos;
        first      = !query_open;
        pk         = punct_tok(b.ch);
        query_open = 1'b1;
        case (lex_mode)
            MODE_WORD: begin
                if (is_space(b.ch) || pk != TK_NAME) begin
                    add_token(word_tok(), tok_start, tok_len, 1'b0, 1'b0);
                    lex_mode = MODE_START;
                    if (pk != TK_NAME) add_token(pk, pos, 16'd1, 1'b0, 1'b0);
                end else begin
                    if (tok_len < WORD_CHARS) word_buf[tok_len] = b.ch;
                    if (tok_len != LEN_SAT) tok_len++;
                end
            end
            MODE_QUOTE: begin
                if (b.ch == ASC_QUOTE) begin
                    add_token(TK_NAME, tok_start, tok_len, 1'b0, 1'b0);
                    lex_mode = MODE_START;
                end else if (tok_len != LEN_SAT) begin
                    tok_len++;
                end
            end
            default: begin
                lex_mode = MODE_START;
                if (b.ch == ASC_QUOTE) begin
                    lex_mode  = MODE_QUOTE;
                    tok_start = (pos < POS_SAT) ? pos + 16'd1 : pos;
                    tok_len   = '0;
                end else if (pk != TK_NAME) begin
                    add_token(pk, pos, 16'd1, 1'b0, 1'b0);
                end else if (is_space(b.ch)) begin
                    // whitespace opening a query yields an empty name
                    if (first) add_token(TK_NAME, pos, 16'd0, 1'b0, 1'b0);
                end else begin
                    lex_mode    = MODE_WORD;
                    tok_start   = pos;
                    tok_len     = 16'd1;
                    word_buf[0] = b.ch;
                end
            end
        endcase
        lex_pos = (pos < POS_SAT) ? pos + 16'd1 : pos;
        if (b.last) begin
            if (lex_mode == MODE_QUOTE) begin
                // open quote at the end: only the error marker, no name
                add_token(TK_END, tok_start, tok_len, 1'b1, 1'b1);
            end else begin
                if (lex_mode == MODE_WORD)
                    add_token(word_tok(), tok_start, tok_len, 1'b0, 1'b0);
                add_token(TK_END, lex_pos, 16'd0, 1'b0, 1'b1);
            end
            lex_mode   = MODE_START;
            lex_pos    = '0;
            tok_start  = '0;
            tok_len    = '0;
            query_open = 1'b0;
        end
    endtask

    function automatic int tx_idle_pct(input t_phase p);
        case (p)
            PH_TX_GAPS: return 52;
            PH_BOTH:    return 22;
            default:    return 0;
        endcase
    endfunction

    function automatic int rx_stall_pct(input t_phase p);
        case (p)
            PH_RX_STALLS: return 52;
            PH_BOTH:      return 22;
            default:      return 0;
        endcase
    endfunction

    // sender: a word may leave the queue once the previous one was taken, unless an idle gap is drawn
    always @(posedge i_clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (in_valid) lex_byte(in_data);
            if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle_pct(phase)) begin
                in_valid <= 1'b1;
                in_data  <= byte_q.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (phase == PH_HOLD && hold_count < HOLD_CYCLES) begin
            out_stall  <= 1'b1;
            hold_count <= hold_count + 1;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct(phase));
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_tokens.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected token: kind %0d start %0d len %0d",
                             o_out_data.kind, o_out_data.start_res, o_out_data.length);
            end else begin
                next_token = expected_tokens.pop_front();
                if (o_out_data.kind !== next_token.kind ||
                        o_out_data.start_res !== next_token.start_res ||
                        o_out_data.length !== next_token.length ||
                        o_out_data.status !== next_token.status ||
                        o_out_data.final_res !== next_token.final_res) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("token mismatch (exp/got): kind %0d/%0d start %0d/%0d",
                               next_token.kind, o_out_data.kind,
                               next_token.start_res, o_out_data.start_res);
                        $display(" len %0d/%0d status %0d/%0d final %0d/%0d",
                                 next_token.length, o_out_data.length,
                                 next_token.status, o_out_data.status,
                                 next_token.final_res, o_out_data.final_res);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("DONE: errors detected");
                    $finish;
                end
            end
        end
    end

    task automatic put_byte(input logic [7:0] c);
        pending_text.insert(pending_text.size(), c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic close_query();
        t_in b;
        while (pending_text.size() != 0) begin
            b.ch   = pending_text.pop_front();
            b.last = (pending_text.size() == 0);
            byte_q.insert(byte_q.size(), b);
            queued_bytes++;
        end
    endtask

    function automatic logic [7:0] random_space();
        logic [7:0] v;
        v = 8'($urandom_range(8, 13));
        return (v < ASC_TAB) ? ASC_SPACE : v;
    endfunction

    function automatic logic [7:0] name_char();
        string pool;
        pool = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_abcdefxyz0189";
        return pool[$urandom_range(pool.len() - 1)];
    endfunction

    function automatic logic [7:0] non_quote();
        logic [7:0] v;
        do v = 8'($urandom_range(255)); while (v == ASC_QUOTE);
        return v;
    endfunction

    function automatic logic [7:0] punct_char();
        string pool;
        pool = "(),";
        return pool[$urandom_range(2)];
    endfunction

    task automatic random_query();
        int n;
        if ($urandom_range(5) == 0) put_byte(random_space());
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(9))
                0, 1, 2, 3: put_text(kw_words[$urandom_range(KW_WORDS - 1)]);
                4: put_text(kw_words[$urandom_range(KW_WORDS - 1)].tolower());
                5: begin
                    n = ($urandom_range(4) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
                    repeat (n) put_byte(name_char());
                end
                6: begin
                    put_byte(ASC_QUOTE);
                    repeat ($urandom_range(0, 5)) put_byte(non_quote());
                    put_byte(ASC_QUOTE);
                end
                7: put_byte(punct_char());
                8: put_byte(8'($urandom_range(255)));
                default: begin
                    put_byte(name_char());
                    put_byte(ASC_QUOTE);
                    put_byte(name_char());
                end
            endcase
            case ($urandom_range(3))
                0: ;
                1: put_byte(random_space());
                2: begin
                    put_byte(random_space());
                    put_byte(random_space());
                end
                default: put_byte(punct_char());
            endcase
        end
        if ($urandom_range(7) == 0) begin
            put_byte(ASC_QUOTE);
            repeat ($urandom_range(0, 3)) put_byte(non_quote());
        end
        close_query();
    endtask

    task automatic random_bytes(input int n);
        int target;
        target = queued_bytes + n;
        while (queued_bytes < target) random_query();
    endtask

    // test holds back new queries until every queued word is taken and answered
    task automatic drain();
        do @(negedge i_clk);
        while (byte_q.size() != 0 || in_valid || expected_tokens.size() != 0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        phase = PH_STEADY;
        put_byte(ASC_TAB);
        close_query();
        put_text("'a");
        close_query();
        put_text("a'b)");
        close_query();
        put_text("SELECT");
        close_query();
        put_text("''");
        close_query();
        put_byte(8'hFF);
        put_byte(8'h00);
        close_query();
        put_byte(ASC_COMMA);
        close_query();
        put_text("AS(");
        close_query();
        drain();

        random_bytes(PHASE_BYTES);
        drain();

        phase = PH_TX_GAPS;
        random_bytes(PHASE_BYTES);
        drain();

        phase = PH_RX_STALLS;
        random_bytes(PHASE_BYTES);
        drain();

        phase = PH_BOTH;
        random_bytes(PHASE_BYTES);
        drain();

        // output held off while punctuation keeps arriving
        phase = PH_HOLD;
        repeat (5) put_text("(,)");
        close_query();
        drain();

        repeat (20) @(posedge i_clk);
        errors += expected_tokens.size();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/sqlkt_pkg.sv
hw/rtl/sqlkt_kw_match.sv
hw/rtl/sqlkt_lexer.sv
hw/rtl/sqlkt_res_fifo.sv
hw/rtl/sql_keyword_tokenizer.sv
hw/rtl/sqlkt_checker.sv
tb/tb_sql_keyword_tokenizer.sv
